// ===== hdl/vtp_pkg.sv =====
// ---------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants for the vertex transform and perspective divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int DIMENSION  = 4;
    localparam int COEF_W     = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 32;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int PROD_W     = DATA_WIDTH + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHR_W      = SUM_W - FRAC_SHIFT;
    // dividend is t * 256, magnitude up to 2^(DATA_WIDTH+7)
    localparam int NUM_W      = DATA_WIDTH + 8;
    localparam int LANES      = 3;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] ONE_Q8   = DATA_WIDTH'(256);

    localparam logic [REG_W-1:0] COEF_RESET [NUM_REGS] = '{
        32'd4096, 32'd0, 32'd268435456, 32'd0,
        32'd0, 32'd4096, 32'd0, 32'd268435456
    };

    typedef struct packed {
        logic                         mode;
        logic signed [DATA_WIDTH-1:0] in_x;
        logic signed [DATA_WIDTH-1:0] in_y;
        logic signed [DATA_WIDTH-1:0] in_z;
        logic signed [DATA_WIDTH-1:0] in_w;
    } t_vtx_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_x;
        logic signed [DATA_WIDTH-1:0] out_y;
        logic signed [DATA_WIDTH-1:0] out_z;
        logic signed [DATA_WIDTH-1:0] out_w;
        logic                         zero_w;
        logic                         saturated;
    } t_vtx_out;

    // one step of the divider chain: sideband plus three quotient lanes
    typedef struct packed {
        logic                                 valid;
        logic                                 mode;
        logic                                 zw;
        logic                                 tsat;
        logic        [LANES-1:0][DATA_WIDTH-1:0] tval;
        logic signed [DATA_WIDTH-1:0]         tw;
        logic        [DATA_WIDTH-1:0]         div;
        logic        [LANES-1:0]              neg;
        logic        [LANES-1:0][DATA_WIDTH-1:0] rem;
        logic        [LANES-1:0][NUM_W-1:0]   acc;
    } t_div_stage;

endpackage

`default_nettype wire

// ===== hdl/vtp_mac_row.sv =====
// ---------------------------------------------------------------------------
// vtp_mac_row
// One matrix row: four registered products, then sum, floor shift, saturate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtp_mac_row (
    input  wire logic                                         i_clk,
    input  wire logic [vtp_pkg::DIMENSION-1:0][vtp_pkg::COEF_W-1:0]     i_coef,
    input  wire logic [vtp_pkg::DIMENSION-1:0][vtp_pkg::DATA_WIDTH-1:0] i_vec,
    output logic signed [vtp_pkg::DATA_WIDTH-1:0]            o_t,
    output logic                                              o_sat
);
    import vtp_pkg::*;

    logic signed [PROD_W-1:0] r_prod [DIMENSION];
    logic signed [PROD_W-1:0] n_prod [DIMENSION];
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SHR_W-1:0]  w_shr;
    logic signed [DATA_WIDTH-1:0] n_t;
    logic                     n_sat;

    always_comb begin
        for (int c = 0; c < DIMENSION; c++) begin
            n_prod[c] = $signed(i_coef[c]) * $signed(i_vec[c]);
        end
    end

    always_comb begin
        w_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
              + SUM_W'(r_prod[3]);
        w_shr = w_sum[SUM_W-1:FRAC_SHIFT];
        if (w_shr > SHR_W'(DATA_MAX)) begin
            n_t   = DATA_MAX;
            n_sat = 1'b1;
        end else if (w_shr < SHR_W'(DATA_MIN)) begin
            n_t   = DATA_MIN;
            n_sat = 1'b1;
        end else begin
            n_t   = w_shr[DATA_WIDTH-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        o_t    <= n_t;
        o_sat  <= n_sat;
    end

endmodule

`default_nettype wire

// ===== hdl/vtp_div_cell.sv =====
// ---------------------------------------------------------------------------
// vtp_div_cell
// One restoring-division step for three lanes; retires one quotient bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtp_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vtp_pkg::t_div_stage i_stage,
    output vtp_pkg::t_div_stage      o_stage
);
    import vtp_pkg::*;

    t_div_stage                n_stage;
    logic [DATA_WIDTH:0]       w_sh [LANES];
    logic [LANES-1:0]          w_ge;

    always_comb begin
        n_stage = i_stage;
        for (int l = 0; l < LANES; l++) begin
            // shift next dividend bit into the partial remainder
            w_sh[l] = {i_stage.rem[l], i_stage.acc[l][NUM_W-1]};
            w_ge[l] = (w_sh[l] >= {1'b0, i_stage.div});
            n_stage.rem[l] = w_ge[l] ? DATA_WIDTH'(w_sh[l] - {1'b0, i_stage.div})
                                     : w_sh[l][DATA_WIDTH-1:0];
            n_stage.acc[l] = {i_stage.acc[l][NUM_W-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage.valid <= 1'b0;
        end else begin
            o_stage.valid <= n_stage.valid;
        end
        o_stage.mode <= n_stage.mode;
        o_stage.zw   <= n_stage.zw;
        o_stage.tsat <= n_stage.tsat;
        o_stage.tval <= n_stage.tval;
        o_stage.tw   <= n_stage.tw;
        o_stage.div  <= n_stage.div;
        o_stage.neg  <= n_stage.neg;
        o_stage.rem  <= n_stage.rem;
        o_stage.acc  <= n_stage.acc;
    end

endmodule

`default_nettype wire

// ===== hdl/vertex_transform_project.sv =====
// ---------------------------------------------------------------------------
// vertex_transform_project
// 4x4 Q4.12 matrix times Q8.8 vertex, optional divide by transformed w.
// ---------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  request  | i_start, o_busy, i_req                 | taken when i_start & !o_busy
//  result   | o_valid, o_res                         | one-cycle strobe, no stall
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data        | write when i_cfg_we
//
//  One request per cycle; o_busy stays low. Each result passes through the
//  product and sum registers, the setup register, 24 divider cells (one
//  quotient bit each) and the output register. Mode 0 requests ride the same chain.
//  Synchronous reset clears the valid chain and loads the identity matrix.
//  The receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_project (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire vtp_pkg::t_vtx_in            i_req,
    output logic                             o_valid,
    output vtp_pkg::t_vtx_out                o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [vtp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vtp_pkg::REG_W-1:0]   i_cfg_data
);
    import vtp_pkg::*;

    localparam int LATENCY = NUM_W + 4;

    logic [REG_W-1:0] r_coef [NUM_REGS];
    logic             w_accept;
    logic [1:0]       r_vld;
    logic [1:0]       r_mode;
    logic [DIMENSION-1:0][DATA_WIDTH-1:0] w_vec;
    logic signed [DATA_WIDTH-1:0] w_t   [DIMENSION];
    logic [DIMENSION-1:0]         w_tsat;
    t_div_stage       w_stage [NUM_W+1];
    t_div_stage       n_setup;
    t_vtx_out         n_res;
    logic             n_valid;
    logic signed [NUM_W-1:0] w_num [LANES];
    logic signed [NUM_W:0]   w_q   [LANES];
    logic [LANES-1:0]        w_qsat;
    logic [DATA_WIDTH-1:0]   w_qv  [LANES];
    t_div_stage       w_last;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy && i_rst_n;
    assign w_vec    = {i_req.in_w, i_req.in_z, i_req.in_y, i_req.in_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIMENSION; g++) begin : g_row
            vtp_mac_row u_row (
                .i_clk  (i_clk),
                .i_coef ({r_coef[2*g+1][REG_W-1:COEF_W], r_coef[2*g+1][COEF_W-1:0],
                          r_coef[2*g][REG_W-1:COEF_W],   r_coef[2*g][COEF_W-1:0]}),
                .i_vec  (w_vec),
                .o_t    (w_t[g]),
                .o_sat  (w_tsat[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], w_accept};
        end
        r_mode <= {r_mode[0], i_req.mode};
    end

    // build dividend magnitudes and divisor for the cell chain
    always_comb begin
        n_setup       = '0;
        n_setup.valid = r_vld[1];
        n_setup.mode  = r_mode[1];
        n_setup.zw    = r_mode[1] && (w_t[3] == '0);
        n_setup.tsat  = |w_tsat;
        n_setup.tw    = w_t[3];
        n_setup.div   = w_t[3][DATA_WIDTH-1] ? DATA_WIDTH'(-w_t[3]) : w_t[3];
        for (int l = 0; l < LANES; l++) begin
            w_num[l]          = {w_t[l], 8'd0};
            n_setup.tval[l]   = w_t[l];
            n_setup.neg[l]    = w_t[l][DATA_WIDTH-1] ^ w_t[3][DATA_WIDTH-1];
            n_setup.acc[l]    = w_num[l][NUM_W-1] ? NUM_W'(-w_num[l]) : w_num[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_stage[0].valid <= 1'b0;
        end else begin
            w_stage[0].valid <= n_setup.valid;
        end
        w_stage[0].mode <= n_setup.mode;
        w_stage[0].zw   <= n_setup.zw;
        w_stage[0].tsat <= n_setup.tsat;
        w_stage[0].tval <= n_setup.tval;
        w_stage[0].tw   <= n_setup.tw;
        w_stage[0].div  <= n_setup.div;
        w_stage[0].neg  <= n_setup.neg;
        w_stage[0].rem  <= n_setup.rem;
        w_stage[0].acc  <= n_setup.acc;
    end

    generate
        for (g = 0; g < NUM_W; g++) begin : g_cell
            vtp_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_stage (w_stage[g]),
                .o_stage (w_stage[g+1])
            );
        end
    endgenerate

    assign w_last = w_stage[NUM_W];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_q[l] = w_last.neg[l] ? -$signed({1'b0, w_last.acc[l]})
                                   : $signed({1'b0, w_last.acc[l]});
            if (w_q[l] > (NUM_W+1)'(DATA_MAX)) begin
                w_qv[l]   = DATA_MAX;
                w_qsat[l] = 1'b1;
            end else if (w_q[l] < (NUM_W+1)'(DATA_MIN)) begin
                w_qv[l]   = DATA_MIN;
                w_qsat[l] = 1'b1;
            end else begin
                w_qv[l]   = w_q[l][DATA_WIDTH-1:0];
                w_qsat[l] = 1'b0;
            end
        end
        n_valid = w_last.valid;
        n_res   = '0;
        if (!w_last.mode) begin
            n_res.out_x     = w_last.tval[0];
            n_res.out_y     = w_last.tval[1];
            n_res.out_z     = w_last.tval[2];
            n_res.out_w     = w_last.tw;
            n_res.saturated = w_last.tsat;
        end else if (w_last.zw) begin
            n_res.out_w  = ONE_Q8;
            n_res.zero_w = 1'b1;
        end else begin
            n_res.out_x     = w_qv[0];
            n_res.out_y     = w_qv[1];
            n_res.out_z     = w_qv[2];
            n_res.out_w     = ONE_Q8;
            n_res.saturated = w_last.tsat || (|w_qsat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= n_valid;
        end
        o_res <= n_res;
    end

    // every result must trace back to an accepted request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without matching request");

    // zero divisor gives zero vector, unit w and no clamp flag
    a_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.zero_w) |-> (o_res.out_x == '0 && o_res.out_y == '0 &&
            o_res.out_z == '0 && o_res.out_w == ONE_Q8 && !o_res.saturated))
        else $error("zero w result malformed");

    // divider setup: a flagged zero divisor always carries a zero magnitude
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage[0].valid && w_stage[0].zw) |-> (w_stage[0].div == '0))
        else $error("zero w flag disagrees with divisor");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_transform_project. It drives vertex requests
// with random gaps and programs coefficient matrices between phases. A local
// matrix-vector and perspective-divide predictor queues the expected vertices,
// and each result strobe is compared field by field against the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import vtp_pkg::*;

    localparam int PIPE_LAT = 28;
    localparam int MODE_XFORM = 0;
    localparam int MODE_PROJECT = 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    t_vtx_in           i_req;
    logic              o_valid;
    t_vtx_out          o_res;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_idx;
    logic [REG_W-1:0]  i_cfg_data;

    logic [REG_W-1:0]  coef_shadow [NUM_REGS];
    t_vtx_out          expected_vertices [$];
    int                error_count = 0;

    vertex_transform_project DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint clamp_q88(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic t_vtx_out transform_vertex(t_vtx_in vin);
        t_vtx_out res;
        longint   comp [4];
        longint   tv [4];
        longint   acc;
        longint   cf;
        bit       tsat;
        bit       qsat;
        tsat = 1'b0;
        qsat = 1'b0;
        comp[0] = longint'(vin.in_x);
        comp[1] = longint'(vin.in_y);
        comp[2] = longint'(vin.in_z);
        comp[3] = longint'(vin.in_w);
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) begin
                cf = longint'($signed(coef_shadow[r*2 + c/2][(c%2)*16 +: 16]));
                acc += cf * comp[c];
            end
            // arithmetic shift floors toward minus infinity
            tv[r] = clamp_q88(acc >>> FRAC_SHIFT, tsat);
        end
        res.zero_w = 1'b0;
        if (vin.mode == 1'(MODE_XFORM)) begin
            res.out_x = 16'(tv[0]);
            res.out_y = 16'(tv[1]);
            res.out_z = 16'(tv[2]);
            res.out_w = 16'(tv[3]);
        end else begin
            res.out_w = 16'(256);
            if (tv[3] == 0) begin
                res.zero_w = 1'b1;
                tsat = 1'b0;
                res.out_x = '0;
                res.out_y = '0;
                res.out_z = '0;
            end else begin
                res.out_x = 16'(clamp_q88((tv[0] * 256) / tv[3], qsat));
                res.out_y = 16'(clamp_q88((tv[1] * 256) / tv[3], qsat));
                res.out_z = 16'(clamp_q88((tv[2] * 256) / tv[3], qsat));
            end
        end
        res.saturated = tsat | qsat;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_vtx_out exp_v;
        if (i_rst_n && o_valid) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected result %h", o_res);
                error_count++;
            end else begin
                exp_v = expected_vertices.pop_front();
                if (o_res.out_x !== exp_v.out_x) begin
                    $error("out_x expected %h actual %h", exp_v.out_x, o_res.out_x);
                    error_count++;
                end
                if (o_res.out_y !== exp_v.out_y) begin
                    $error("out_y expected %h actual %h", exp_v.out_y, o_res.out_y);
                    error_count++;
                end
                if (o_res.out_z !== exp_v.out_z) begin
                    $error("out_z expected %h actual %h", exp_v.out_z, o_res.out_z);
                    error_count++;
                end
                if (o_res.out_w !== exp_v.out_w) begin
                    $error("out_w expected %h actual %h", exp_v.out_w, o_res.out_w);
                    error_count++;
                end
                if (o_res.zero_w !== exp_v.zero_w) begin
                    $error("zero_w expected %b actual %b", exp_v.zero_w, o_res.zero_w);
                    error_count++;
                end
                if (o_res.saturated !== exp_v.saturated) begin
                    $error("saturated expected %b actual %b",
                           exp_v.saturated, o_res.saturated);
                    error_count++;
                end
            end
        end
    end

    task automatic send_vertex(t_vtx_in vin);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= vin;
        do @(posedge i_clk); while (o_busy);
        expected_vertices.push_back(transform_vertex(vin));
    endtask

    // drop start and let the pipeline empty before touching the matrix
    task automatic drain_pipe();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_coef(int idx, logic [REG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= IDX_W'(idx);
        i_cfg_data <= value;
        @(posedge i_clk);
        coef_shadow[idx] = value;
    endtask

    task automatic load_matrix(logic [15:0] m [4][4]);
        drain_pipe();
        for (int r = 0; r < 4; r++) begin
            write_coef(r*2, {m[r][1], m[r][0]});
            write_coef(r*2 + 1, {m[r][3], m[r][2]});
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return 16'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function automatic t_vtx_in rand_vertex();
        t_vtx_in v;
        v.mode = 1'($urandom);
        v.in_x = rand_word();
        v.in_y = rand_word();
        v.in_z = rand_word();
        v.in_w = ($urandom_range(0, 7) == 0) ? 16'h0000 : rand_word();
        return v;
    endfunction

    task automatic test_identity_directed();
        t_vtx_in v;
        logic [15:0] edges [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100,
                                    16'hFF00, 16'h0001};
        for (int i = 0; i < 6; i++) begin
            for (int md = 0; md < 2; md++) begin
                v.mode = 1'(md);
                v.in_x = edges[i];
                v.in_y = edges[(i + 1) % 6];
                v.in_z = edges[(i + 2) % 6];
                v.in_w = edges[(i + 3) % 6];
                send_vertex(v);
            end
        end
        // divide by zero w, then divide by tiny w to force quotient clamp
        v = '{1'(MODE_PROJECT), 16'h1234, 16'h8000, 16'h7FFF, 16'h0000};
        send_vertex(v);
        v = '{1'(MODE_PROJECT), 16'h4000, 16'hC000, 16'h0003, 16'h0001};
        send_vertex(v);
        v = '{1'(MODE_PROJECT), 16'h0300, 16'hFD00, 16'h0080, 16'hFF00};
        send_vertex(v);
    endtask

    task automatic test_saturating_matrix();
        logic [15:0] m [4][4];
        t_vtx_in v;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) m[r][c] = 16'h7FFF;
        load_matrix(m);
        v = '{1'(MODE_XFORM), 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        send_vertex(v);
        v = '{1'(MODE_PROJECT), 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        send_vertex(v);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) m[r][c] = 16'h8000;
        load_matrix(m);
        v = '{1'(MODE_XFORM), 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        send_vertex(v);
        v = '{1'(MODE_PROJECT), 16'h7FFF, 16'h0001, 16'h8000, 16'h0002};
        send_vertex(v);
        for (int i = 0; i < 20; i++) send_vertex(rand_vertex());
    endtask

    task automatic test_random_matrices();
        logic [15:0] m [4][4];
        for (int ph = 0; ph < 10; ph++) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++) begin
                    m[r][c] = rand_word();
                    // keep many matrices near unity scale
                    if (ph % 2 == 0 && $urandom_range(0, 1) == 1)
                        m[r][c] = 16'($signed($urandom_range(0, 8191)) - 4096);
                end
            // zero w row makes the divide-by-zero path common
            if (ph == 3) for (int c = 0; c < 4; c++) m[3][c] = 16'h0000;
            load_matrix(m);
            for (int i = 0; i < 50; i++) send_vertex(rand_vertex());
            if (ph == 5) drain_pipe();
        end
    endtask

    task automatic test_identity_restore();
        logic [15:0] m [4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? 16'h1000 : 16'h0000;
        load_matrix(m);
        for (int i = 0; i < 25; i++) send_vertex(rand_vertex());
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) coef_shadow[i] = COEF_RESET[i];
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_directed();
        test_saturating_matrix();
        test_random_matrices();
        test_identity_restore();

        drain_pipe();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
